>>> rtl/odo_pkg.sv
// Shared types and constants of the odometry tracker.
package odo_pkg;

	typedef enum logic [1:0] {
		OP_UPDATE,
		OP_BASE,
		OP_SET
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_HI,
		ST_MUL_LO,
		ST_DIST,
		ST_ROT,
		ST_COEF,
		ST_MUL_X,
		ST_ACC_X,
		ST_ACC_Y,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic full;
		logic valid;
	} fifo_stat_t;

	localparam int CORDIC_STEPS = 24;
	localparam logic [31:0] CORDIC_GAIN_INIT = 32'd652032874;
	localparam logic [31:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
	};

endpackage

>>> rtl/odo_front.sv
// Front end: accepts requests, tracks baselines and heading, computes sums and midpoints.
module odo_front #(
	parameter int ANGLE_BITS = 16,
	parameter int ENC_BITS = 32,
	parameter int EW = 2 + ENC_BITS + 1 + 2 * ANGLE_BITS + 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [159:0]       s_tdata,
	input  logic               s_tuser,
	input  odo_pkg::fifo_stat_t stat,
	output logic               push,
	output logic [EW-1:0]      entry
);

	logic [ENC_BITS-1:0]   last_left_q, last_right_q;
	logic [ANGLE_BITS-1:0] head_q;
	logic                  base_valid_q;

	logic [ENC_BITS-1:0]   left, right, dl, dr;
	logic signed [ENC_BITS:0] sum;
	logic [ANGLE_BITS-1:0] hnew, tset, d, mid, theta;
	odo_pkg::op_t          op;

	assign s_tready = !stat.full;
	assign push     = s_tvalid && s_tready;

	always_comb begin
		left  = s_tdata[ENC_BITS-1:0];
		right = s_tdata[32 +: ENC_BITS];
		hnew  = ANGLE_BITS'(s_tdata[79:64]);
		tset  = ANGLE_BITS'(s_tdata[159:144]);
		dl    = left - last_left_q;
		dr    = right - last_right_q;
		sum   = {dl[ENC_BITS-1], dl} + {dr[ENC_BITS-1], dr};
		d     = hnew - head_q;
		// floor half of the wrapped difference
		mid   = head_q + {d[ANGLE_BITS-1], d[ANGLE_BITS-1:1]};
		if (s_tuser) begin
			op    = odo_pkg::OP_SET;
			theta = tset;
		end else if (!base_valid_q) begin
			op    = odo_pkg::OP_BASE;
			theta = head_q;
		end else begin
			op    = odo_pkg::OP_UPDATE;
			theta = hnew;
		end
		entry = {op, theta, s_tdata[143:112], s_tdata[111:80], mid, sum};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_left_q  <= '0;
			last_right_q <= '0;
			head_q       <= '0;
			base_valid_q <= 1'b0;
		end else if (push) begin
			last_left_q  <= left;
			last_right_q <= right;
			head_q       <= theta;
			base_valid_q <= 1'b1;
		end
	end

endmodule

>>> rtl/odo_fifo.sv
// Two-entry queue between front and back ends.
module odo_fifo #(
	parameter int W = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [W-1:0]       wdata,
	input  logic               pop,
	output logic [W-1:0]       rdata,
	output odo_pkg::fifo_stat_t stat
);

	logic [W-1:0] mem_q [0:1];
	logic         wr_q, rd_q;
	logic [1:0]   cnt_q;

	assign stat.full  = cnt_q == 2'd2;
	assign stat.valid = cnt_q != 2'd0;
	assign rdata      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

>>> rtl/odo_back.sv
// Back end: distance scaling, CORDIC rotation, pose accumulation and result register.
module odo_back #(
	parameter int ANGLE_BITS = 16,
	parameter int POS_BITS = 32,
	parameter int ENC_BITS = 32,
	parameter int EW = 2 + ENC_BITS + 1 + 2 * ANGLE_BITS + 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [31:0]        cfg_wdata,
	input  odo_pkg::fifo_stat_t stat,
	input  logic [EW-1:0]      entry,
	output logic               pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [79:0]        m_tdata
);

	localparam int P  = POS_BITS;
	localparam int E  = ENC_BITS;
	localparam int A  = ANGLE_BITS;
	localparam int DW = (E + 34 > P + 2) ? E + 34 : P + 2;
	localparam int SW = (P > 32 ? P : 32) + 1;
	localparam int MW = P + 17;
	localparam int AW = P + 18;
	localparam logic signed [DW-1:0] DMAX = {{(DW-P){1'b0}}, {P{1'b1}}};
	localparam logic signed [DW-1:0] DRND = DW'(65536);
	localparam logic signed [SW-1:0] SMAX = {{(SW-P+1){1'b0}}, {(P-1){1'b1}}};
	localparam logic signed [AW-1:0] AMAX = {{(AW-P+1){1'b0}}, {(P-1){1'b1}}};
	localparam logic signed [MW-1:0] MRND = MW'(8192);
	localparam logic signed [33:0] HALF_PI = 34'sd1073741824;
	localparam logic signed [33:0] PI_Z = 34'sd2147483648;
	localparam logic signed [33:0] CRND = 34'sd32768;
	localparam logic signed [33:0] UNIT = 34'sd16384;

	odo_pkg::state_t st_q, st_d;

	logic [31:0]            scale_q;
	logic signed [P-1:0]    px_q, py_q;
	logic [A-1:0]           th_q;
	logic signed [E:0]      sum_q;
	logic [A-1:0]           mid_q;
	logic signed [E+17:0]   prod_hi_q, prod_lo_q;
	logic signed [P:0]      dist_q;
	logic signed [33:0]     cx_q, cy_q, cz_q;
	logic                   neg_q;
	logic [4:0]             step_q;
	logic signed [15:0]     c_q, s_q;
	logic signed [MW-1:0]   prod_q;
	logic                   out_valid_q;
	logic [79:0]            out_q;

	odo_pkg::op_t           e_op;
	logic signed [E:0]      e_sum;
	logic [A-1:0]           e_mid, e_theta;
	logic signed [31:0]     e_sx, e_sy;
	logic signed [SW-1:0]   sxw, syw;
	logic signed [P-1:0]    sx_c, sy_c;
	logic signed [DW-1:0]   dfull, dsh;
	logic signed [P:0]      dist_c;
	logic signed [33:0]     z0, xsh, ysh, zt, xr, yr, ct, stt;
	logic signed [15:0]     coef;
	logic signed [MW-1:0]   mul, stepv;
	logic signed [AW-1:0]   acc_a, acc_s;
	logic signed [P-1:0]    acc_c;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	always_comb begin
		{e_op, e_theta, e_sy, e_sx, e_mid, e_sum} = entry;
		sxw = SW'(e_sx);
		syw = SW'(e_sy);
		sx_c = P'(sxw > SMAX ? SMAX : (sxw < ~SMAX ? ~SMAX : sxw));
		sy_c = P'(syw > SMAX ? SMAX : (syw < ~SMAX ? ~SMAX : syw));
		// Q16.16 product from its two halves, rounded and shifted by 17
		dfull = (DW'(prod_hi_q) <<< 16) + DW'(prod_lo_q) + DRND;
		dsh   = dfull >>> 17;
		dist_c = (P+1)'(dsh > DMAX ? DMAX : (dsh < -DMAX ? -DMAX : dsh));
		z0  = 34'(signed'({mid_q, {(32-A){1'b0}}}));
		xsh = cx_q >>> step_q;
		ysh = cy_q >>> step_q;
		zt  = signed'({2'b00, odo_pkg::ATAN_TAB[step_q]});
		xr  = neg_q ? -cx_q : cx_q;
		yr  = neg_q ? -cy_q : cy_q;
		ct  = (xr + CRND) >>> 16;
		stt = (yr + CRND) >>> 16;
		coef  = (st_q == odo_pkg::ST_MUL_X) ? c_q : s_q;
		mul   = dist_q * coef;
		stepv = (prod_q + MRND) >>> 14;
		acc_a = (st_q == odo_pkg::ST_ACC_X) ? AW'(px_q) : AW'(py_q);
		acc_s = acc_a + AW'(stepv);
		acc_c = P'(acc_s > AMAX ? AMAX : (acc_s < ~AMAX ? ~AMAX : acc_s));
	end

	always_comb begin
		st_d = st_q;
		pop  = 1'b0;
		unique case (st_q)
			odo_pkg::ST_IDLE: begin
				if (stat.valid && !out_valid_q) begin
					pop  = 1'b1;
					st_d = (e_op == odo_pkg::OP_UPDATE) ? odo_pkg::ST_MUL_HI
						: odo_pkg::ST_EMIT;
				end
			end
			odo_pkg::ST_MUL_HI: st_d = odo_pkg::ST_MUL_LO;
			odo_pkg::ST_MUL_LO: st_d = odo_pkg::ST_DIST;
			odo_pkg::ST_DIST:   st_d = odo_pkg::ST_ROT;
			odo_pkg::ST_ROT: begin
				if (step_q == 5'(odo_pkg::CORDIC_STEPS - 1)) st_d = odo_pkg::ST_COEF;
			end
			odo_pkg::ST_COEF:   st_d = odo_pkg::ST_MUL_X;
			odo_pkg::ST_MUL_X:  st_d = odo_pkg::ST_ACC_X;
			odo_pkg::ST_ACC_X:  st_d = odo_pkg::ST_ACC_Y;
			odo_pkg::ST_ACC_Y:  st_d = odo_pkg::ST_EMIT;
			odo_pkg::ST_EMIT:   st_d = odo_pkg::ST_IDLE;
			default:            st_d = odo_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= odo_pkg::ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q     <= 32'd65536;
			px_q        <= '0;
			py_q        <= '0;
			th_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) scale_q <= cfg_wdata;
			if (st_q == odo_pkg::ST_EMIT) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			if (pop) begin
				if (e_op == odo_pkg::OP_SET) begin
					px_q <= sx_c;
					py_q <= sy_c;
				end
				th_q <= e_theta;
			end
			if (st_q == odo_pkg::ST_ACC_X) px_q <= acc_c;
			if (st_q == odo_pkg::ST_ACC_Y) py_q <= acc_c;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sum_q <= e_sum;
			mid_q <= e_mid;
		end
		unique case (st_q)
			odo_pkg::ST_MUL_HI: begin
				prod_hi_q <= sum_q * signed'({1'b0, scale_q[31:16]});
				// fold the angle into the right half plane
				cx_q   <= signed'({2'b00, odo_pkg::CORDIC_GAIN_INIT});
				cy_q   <= '0;
				step_q <= '0;
				if (z0 > HALF_PI) begin
					cz_q <= z0 - PI_Z;
					neg_q <= 1'b1;
				end else if (z0 < -HALF_PI) begin
					cz_q <= z0 + PI_Z;
					neg_q <= 1'b1;
				end else begin
					cz_q <= z0;
					neg_q <= 1'b0;
				end
			end
			odo_pkg::ST_MUL_LO: prod_lo_q <= sum_q * signed'({1'b0, scale_q[15:0]});
			odo_pkg::ST_DIST:   dist_q <= dist_c;
			odo_pkg::ST_ROT: begin
				if (cz_q >= 0) begin
					cx_q <= cx_q - ysh;
					cy_q <= cy_q + xsh;
					cz_q <= cz_q - zt;
				end else begin
					cx_q <= cx_q + ysh;
					cy_q <= cy_q - xsh;
					cz_q <= cz_q + zt;
				end
				step_q <= step_q + 5'd1;
			end
			odo_pkg::ST_COEF: begin
				c_q <= 16'(ct > UNIT ? UNIT : (ct < -UNIT ? -UNIT : ct));
				s_q <= 16'(stt > UNIT ? UNIT : (stt < -UNIT ? -UNIT : stt));
			end
			odo_pkg::ST_MUL_X, odo_pkg::ST_ACC_X: prod_q <= mul;
			odo_pkg::ST_EMIT: out_q <= {16'(signed'(th_q)), 32'(py_q), 32'(px_q)};
			default: ;
		endcase
	end

endmodule

>>> rtl/diff_drive_odometry.sv
// Top level of the differential-drive odometry tracker.
// Each request (tuser 0 = encoder/heading update, 1 = set pose) yields one pose result.
// An update passes through the back end as the dequeue, two partial products for the
// distance scale, the distance, the 24-step iterative CORDIC, the coefficients, the x/y
// steps, the result load and the result handshake. Set-pose and the first baseline
// request go from the dequeue straight to the result load and handshake. A
// two-entry queue lets the front accept requests while the back end works or a result
// waits on m_tready.
module diff_drive_odometry #(
	parameter int ANGLE_BITS = 16,
	parameter int POS_BITS = 32,
	parameter int ENC_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wen,
	input  logic [31:0]  cfg_wdata,   // distance_scale, unsigned Q16.16
	input  logic         s_tvalid,
	output logic         s_tready,
	// left_position[31:0], right_position[63:32], heading_angle[79:64],
	// set_x[111:80], set_y[143:112], set_theta[159:144]
	input  logic [159:0] s_tdata,
	input  logic         s_tuser,     // command
	output logic         m_tvalid,
	input  logic         m_tready,
	// pose_x[31:0], pose_y[63:32], pose_theta[79:64]
	output logic [79:0]  m_tdata
);

	localparam int EW = 2 + ENC_BITS + 1 + 2 * ANGLE_BITS + 64;

	odo_pkg::fifo_stat_t stat;
	logic                push, pop;
	logic [EW-1:0]       wentry, rentry;

	odo_front #(.ANGLE_BITS(ANGLE_BITS), .ENC_BITS(ENC_BITS), .EW(EW)) u_front (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.stat, .push, .entry(wentry)
	);

	odo_fifo #(.W(EW)) u_fifo (
		.clk, .arst_n, .push, .wdata(wentry), .pop, .rdata(rentry), .stat
	);

	odo_back #(.ANGLE_BITS(ANGLE_BITS), .POS_BITS(POS_BITS), .ENC_BITS(ENC_BITS),
		.EW(EW)) u_back (
		.clk, .arst_n, .cfg_wen, .cfg_wdata, .stat, .entry(rentry), .pop,
		.m_tvalid, .m_tready, .m_tdata
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full) else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> stat.valid) else $error("queue underflow");

	a_pop_free_out: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !m_tvalid) else $error("request started with result pending");

endmodule

>>> dv/tb_diff_drive_odometry.sv
// Self-checking testbench for the differential-drive odometry tracker.
module tb_diff_drive_odometry;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM = 1800;
	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 80;
	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_SET = 1'b1;
	localparam int STEPS = 24;
	localparam longint GAIN0 = 64'd652032874;
	localparam longint ARCTAN [0:STEPS-1] = '{
		536870912, 316933406, 167458907, 85004756, 42667331,
		21354465, 10679838, 5340245, 2670163, 1335087,
		667544, 333772, 166886, 83443, 41722, 20861,
		10430, 5215, 2608, 1304, 652, 326, 163, 81
	};

	typedef struct packed {
		logic        cmd;
		logic [31:0] left_pos;
		logic [31:0] right_pos;
		logic [15:0] heading;
		logic [31:0] new_x;
		logic [31:0] new_y;
		logic [15:0] new_theta;
	} request_t;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [15:0] theta;
	} pose_t;

	typedef struct {
		request_t req;
		logic     known;
		pose_t    pose;
	} row_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_wen;
	logic [31:0]  cfg_wdata;
	logic         s_tvalid;
	logic         s_tready;
	logic [159:0] s_tdata;
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [79:0]  m_tdata;

	diff_drive_odometry dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// predictor state
	logic [31:0] scale_q16;
	logic [31:0] base_left, base_right;
	longint      track_x, track_y;
	logic [15:0] track_heading;
	logic        have_base;

	pose_t pending_poses[$];
	int    mismatches = 0;
	int    send_idle_pct = 0;
	int    recv_idle_pct = 0;
	int    hold_recv = 0;
	int    quiet_cycles = 0;

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	task automatic cordic_sincos(input logic [15:0] ang, output longint c, output longint s);
		longint z, x, y, nx;
		bit flip;
		z = longint'($signed({ang, 16'h0}));
		x = GAIN0;
		y = 0;
		flip = 0;
		if (z > (64'sd1 <<< 30)) begin
			z -= 64'sd1 <<< 31;
			flip = 1;
		end else if (z < -(64'sd1 <<< 30)) begin
			z += 64'sd1 <<< 31;
			flip = 1;
		end
		for (int i = 0; i < STEPS; i++) begin
			if (z >= 0) begin
				nx = x - floor_shift(y, i);
				y = y + floor_shift(x, i);
				z -= ARCTAN[i];
			end else begin
				nx = x + floor_shift(y, i);
				y = y - floor_shift(x, i);
				z += ARCTAN[i];
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = clip(floor_shift(x + (64'sd1 <<< 15), 16), -16384, 16384);
		s = clip(floor_shift(y + (64'sd1 <<< 15), 16), -16384, 16384);
	endtask

	task automatic track_pose(input request_t r, output pose_t p);
		longint pmax, pmin, sum, hi_p, lo_p, q, rem, fwd, d, c, s;
		logic [31:0] dl, dr;
		logic [15:0] mid, diff;
		pmax = 64'sd2147483647;
		pmin = -pmax - 1;
		if (r.cmd == CMD_SET) begin
			track_x = longint'($signed(r.new_x));
			track_y = longint'($signed(r.new_y));
			track_heading = r.new_theta;
			have_base = 1;
		end else if (have_base) begin
			dl = r.left_pos - base_left;
			dr = r.right_pos - base_right;
			sum = longint'($signed(dl)) + longint'($signed(dr));
			hi_p = sum * longint'(scale_q16[31:16]);
			lo_p = sum * longint'(scale_q16[15:0]);
			q = floor_shift(hi_p, 1);
			rem = hi_p - 2 * q;
			fwd = q + floor_shift(rem * 65536 + lo_p + 65536, 17);
			fwd = clip(fwd, -64'sd4294967295, 64'sd4294967295);
			diff = r.heading - track_heading;
			d = longint'($signed(diff));
			mid = track_heading + 16'(floor_shift(d, 1));
			cordic_sincos(mid, c, s);
			track_x = clip(track_x + floor_shift(fwd * c + 8192, 14), pmin, pmax);
			track_y = clip(track_y + floor_shift(fwd * s + 8192, 14), pmin, pmax);
			track_heading = r.heading;
		end
		have_base = 1;
		base_left = r.left_pos;
		base_right = r.right_pos;
		p.x = track_x[31:0];
		p.y = track_y[31:0];
		p.theta = track_heading;
	endtask

	function automatic row_t mk(logic cmd, logic [31:0] l, logic [31:0] rr, logic [15:0] h,
			logic [31:0] sx, logic [31:0] sy, logic [15:0] st, logic known = 0,
			logic [31:0] ex = 0, logic [31:0] ey = 0, logic [15:0] et = 0);
		row_t t;
		t.req = '{cmd, l, rr, h, sx, sy, st};
		t.known = known;
		t.pose = '{ex, ey, et};
		return t;
	endfunction

	task automatic write_scale(input logic [31:0] v);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		scale_q16 = v;
	endtask

	task automatic wait_drained();
		while (pending_poses.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// offer one request; valid stays high across back-to-back requests
	task automatic send_request(input request_t r);
		pose_t p;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= r.cmd;
		s_tdata <= {r.new_theta, r.new_y, r.new_x, r.heading, r.right_pos, r.left_pos};
		do @(posedge clk); while (!s_tready);
		track_pose(r, p);
		pending_poses.push_back(p);
	endtask

	task automatic stop_sending();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic request_t random_request(int mode);
		request_t r;
		logic [31:0] step_l, step_r;
		r.cmd = ($urandom_range(99) < 6) ? CMD_SET : CMD_UPDATE;
		r.new_x = $urandom;
		r.new_y = $urandom;
		r.new_theta = 16'($urandom);
		r.heading = (mode == 0) ? track_heading + 16'($signed(9'($urandom))) : 16'($urandom);
		if (mode == 0) begin
			step_l = 32'($signed(13'($urandom)));
			step_r = 32'($signed(13'($urandom)));
		end else begin
			step_l = $urandom;
			step_r = $urandom;
		end
		r.left_pos = base_left + step_l;
		r.right_pos = base_right + step_r;
		return r;
	endfunction

	// result side: ready pattern and checking
	always @(posedge clk) begin
		pose_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.x = m_tdata[31:0];
			got.y = m_tdata[63:32];
			got.theta = m_tdata[79:64];
			if (pending_poses.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected pose x=%h y=%h th=%h", got.x, got.y, got.theta);
			end else begin
				want = pending_poses.pop_front();
				if (got.x !== want.x || got.y !== want.y || got.theta !== want.theta) begin
					mismatches++;
					if (mismatches <= 10)
						$display("pose mismatch: exp x=%h y=%h th=%h got x=%h y=%h th=%h",
							want.x, want.y, want.theta, got.x, got.y, got.theta);
				end
			end
		end
		if (hold_recv > 0) begin
			hold_recv <= hold_recv - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
		end
	end

	// watchdog on lack of progress
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			quiet_cycles <= 0;
		else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	row_t directed[$];

	initial begin
		pose_t p;
		request_t r;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		scale_q16 = 32'd65536;
		base_left = 0;
		base_right = 0;
		track_x = 0;
		track_y = 0;
		track_heading = 0;
		have_base = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first update only takes the baseline
		directed.push_back(mk(CMD_UPDATE, 32'h8000_0000, 32'h7fff_ffff, 16'h1234, 0, 0, 0,
			1, 0, 0, 0));
		directed.push_back(mk(CMD_UPDATE, 32'h8000_0400, 32'h8000_03ff, 16'h0000, 0, 0, 0));
		directed.push_back(mk(CMD_SET, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 16'h8000,
			1, 32'h7fff_ffff, 32'h8000_0000, 16'h8000));
		directed.push_back(mk(CMD_UPDATE, 1000, 1000, 16'h8000, 0, 0, 0));
		directed.push_back(mk(CMD_SET, 0, 0, 0, 0, 0, 16'h0000, 1, 0, 0, 0));
		// half a turn apart
		directed.push_back(mk(CMD_UPDATE, 5000, 5000, 16'h8000, 0, 0, 0));
		directed.push_back(mk(CMD_UPDATE, 6000, 6000, 16'h0000, 0, 0, 0));
		// wrap of the heading
		directed.push_back(mk(CMD_UPDATE, 7000, 8000, 16'hfff0, 0, 0, 0));
		directed.push_back(mk(CMD_UPDATE, 9000, 8000, 16'h0010, 0, 0, 0));
		directed.push_back(mk(CMD_UPDATE, 9000, 8000, 16'h4000, 0, 0, 0));
		directed.push_back(mk(CMD_UPDATE, 9000, 8000, 16'hc000, 0, 0, 0));
		// huge encoder jumps, both directions
		directed.push_back(mk(CMD_UPDATE, 32'h8000_2328, 32'h8000_1f40, 16'h2000, 0, 0, 0));
		directed.push_back(mk(CMD_UPDATE, 32'h0000_2328, 32'h0000_1f40, 16'h2000, 0, 0, 0));
		directed.push_back(mk(CMD_UPDATE, 32'h7fff_ffff, 32'h7fff_ffff, 16'hffff, 0, 0, 0));
		directed.push_back(mk(CMD_UPDATE, 32'h8000_0000, 32'h8000_0000, 16'h6000, 0, 0, 0));
		directed.push_back(mk(CMD_SET, 32'hffff_ffff, 32'h0, 0, 32'h8000_0000, 32'h7fff_ffff,
			16'h7fff, 1, 32'h8000_0000, 32'h7fff_ffff, 16'h7fff));
		directed.push_back(mk(CMD_UPDATE, 32'h7fff_ffff, 32'h8000_0001, 16'h7fff, 0, 0, 0));

		foreach (directed[i]) begin
			send_request(directed[i].req);
			if (directed[i].known) begin
				p = pending_poses[$];
				if (p !== directed[i].pose) begin
					mismatches++;
					if (mismatches <= 10)
						$display("directed row %0d: predictor %h table %h", i, p,
							directed[i].pose);
				end
			end
		end
		stop_sending();
		wait_drained();

		// scale extremes with huge steps, so that at the largest scale the distance saturates
		write_scale(32'hffff_ffff);
		repeat (6) send_request(random_request(1));
		stop_sending();
		wait_drained();
		write_scale(32'h0000_0000);
		repeat (6) send_request(random_request(1));
		stop_sending();
		wait_drained();
		write_scale(32'h0000_0001);

		// long receiver hold-off while requests keep coming
		hold_recv = 600;
		repeat (12) send_request(random_request(0));
		stop_sending();
		wait_drained();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 86 : 0;
			recv_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 19 : 0;
			write_scale((phase == 0) ? 32'h0001_0000 : (phase == 1) ? $urandom : 32'h0003_4000);
			for (int n = 0; n < N_RANDOM / 3; n++) begin
				r = random_request(($urandom_range(99) < 85) ? 0 : 1);
				send_request(r);
				if ($urandom_range(199) == 0) begin
					stop_sending();
					while (pending_poses.size() != 0) @(posedge clk);
				end
			end
			stop_sending();
			wait_drained();
		end

		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> sim.f
rtl/odo_pkg.sv
rtl/odo_front.sv
rtl/odo_fifo.sv
rtl/odo_back.sv
rtl/diff_drive_odometry.sv
dv/tb_diff_drive_odometry.sv
